// ===== hdl/tgs_pkg.sv =====
// ---------------------------------------------------------------------------
// tgs_pkg: shared types and constants for the gather/scatter address generator
// Holds field widths, register indexes, the per-stage lane record and helpers.
// ---------------------------------------------------------------------------
package tgs_pkg;

   localparam int NUM_DIMS   = 4;
   localparam int DIM_BITS   = 16;
   localparam int POS_BITS   = 64;
   localparam int IDX_BITS   = 32;
   // a stride is the product of all sizes but the outermost
   localparam int STR_BITS   = (NUM_DIMS - 1) * DIM_BITS;
   localparam int RANK_BITS  = 3;
   localparam int CSR_IDX_BITS = 3;
   localparam int DIM_SEL_BITS = $clog2(NUM_DIMS);
   // one cell per quotient bit, one digit per dimension
   localparam int NUM_CELLS  = NUM_DIMS * POS_BITS;
   localparam int REQ_BITS   = POS_BITS + NUM_DIMS * IDX_BITS;
   localparam int RSP_BITS   = ((2 * POS_BITS + 1 + 7) / 8) * 8;

   // configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_RANK  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MASK  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE0 = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE1 = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE2 = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE3 = 3'd5;

   typedef logic [NUM_DIMS-1:0][DIM_BITS-1:0] coord_vec_type;

   // one request in flight through the cell row
   typedef struct packed {
      logic                valid;
      logic [POS_BITS-1:0] q;      // dividend shifting into quotient
      logic [DIM_BITS-1:0] r;      // partial remainder
      coord_vec_type       coord;  // coordinate per dimension
      logic                err;
   } lane_type;

   // a size of zero behaves as one
   function automatic logic [DIM_BITS-1:0] eff_size(input logic [DIM_BITS-1:0] s);
      eff_size = (s == '0) ? DIM_BITS'(1) : s;
   endfunction

endpackage

// ===== hdl/tgs_index.sv =====
// ---------------------------------------------------------------------------
// tgs_index: entry stage
// Wraps and clamps the index values of indexed dimensions and loads a lane.
// ---------------------------------------------------------------------------
module tgs_index (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      en,
   input  logic                                      req_valid,
   input  logic [tgs_pkg::POS_BITS-1:0]              position,
   input  logic [tgs_pkg::NUM_DIMS-1:0][tgs_pkg::IDX_BITS-1:0] index,
   input  tgs_pkg::coord_vec_type                    size,
   input  logic [tgs_pkg::NUM_DIMS-1:0]              indexed,
   output tgs_pkg::lane_type                         lane_out
);
   import tgs_pkg::*;

   lane_type lane_in, lane_ff;

   // wrap once, clamp and flag each indexed dimension
   always_comb begin
      logic signed [IDX_BITS+1:0] v;
      logic signed [IDX_BITS+1:0] s;
      lane_in       = '0;
      lane_in.valid = req_valid;
      lane_in.q     = position;
      for (int d = 0; d < NUM_DIMS; d++) begin
         s = $signed({{(IDX_BITS+2-DIM_BITS){1'b0}}, size[d]});
         v = $signed({{2{index[d][IDX_BITS-1]}}, index[d]});
         if (v < 0) v = v + s;
         if (indexed[d]) begin
            if (v < 0) begin
               lane_in.coord[d] = '0;
               lane_in.err      = 1'b1;
            end else if (v >= s) begin
               lane_in.coord[d] = size[d] - DIM_BITS'(1);
               lane_in.err      = 1'b1;
            end else begin
               lane_in.coord[d] = v[DIM_BITS-1:0];
            end
         end
      end
   end

   // hold while the row is stalled
   always_ff @(posedge clock) begin
      if (reset) lane_ff <= '0;
      else if (en) lane_ff <= lane_in;
   end

   assign lane_out = lane_ff;
endmodule

// ===== hdl/tgs_cell.sv =====
// ---------------------------------------------------------------------------
// tgs_cell: one restoring division step
// Shifts one dividend bit into the remainder and emits one quotient bit;
// the last cell of a digit stores the remainder as a coordinate when wr is set.
// ---------------------------------------------------------------------------
module tgs_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  tgs_pkg::lane_type                lane_in,
   input  logic [tgs_pkg::DIM_BITS-1:0]     divisor,
   input  logic                             last,
   input  logic                             wr,
   input  logic [tgs_pkg::DIM_SEL_BITS-1:0] dim,
   output tgs_pkg::lane_type                lane_out
);
   import tgs_pkg::*;

   lane_type            step_in, lane_ff;
   logic [DIM_BITS:0]   trial;
   logic [DIM_BITS:0]   rem;
   logic                ge;

   // compare and subtract, then advance the quotient
   always_comb begin
      trial   = {lane_in.r, lane_in.q[POS_BITS-1]};
      ge      = trial >= {1'b0, divisor};
      rem     = ge ? trial - {1'b0, divisor} : trial;
      step_in = lane_in;
      step_in.q = {lane_in.q[POS_BITS-2:0], ge};
      step_in.r = rem[DIM_BITS-1:0];
      if (last) begin
         if (wr) step_in.coord[dim] = rem[DIM_BITS-1:0];
         step_in.r = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) lane_ff <= '0;
      else if (en) lane_ff <= step_in;
   end

   assign lane_out = lane_ff;
endmodule

// ===== hdl/tgs_offset.sv =====
// ---------------------------------------------------------------------------
// tgs_offset: offset assembly
// Multiplies each coordinate by its stride, then sums into the response.
// ---------------------------------------------------------------------------
module tgs_offset (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  en,
   input  tgs_pkg::lane_type                                     lane_in,
   input  logic [tgs_pkg::NUM_DIMS-1:0][tgs_pkg::STR_BITS-1:0]   stride,
   output logic                                                  out_valid,
   output logic [tgs_pkg::POS_BITS-1:0]                          out_offset,
   output logic [tgs_pkg::POS_BITS-1:0]                          out_bcast,
   output logic                                                  out_err
);
   import tgs_pkg::*;

   logic [NUM_DIMS-1:0][POS_BITS-1:0] prod_in, prod_ff;
   logic                              mul_valid_ff, mul_err_ff;
   logic [POS_BITS-1:0]               mul_bcast_ff;
   logic [POS_BITS-1:0]               sum_in, sum_ff, bcast_ff;
   logic                              valid_ff, err_ff;

   // coordinate times stride per dimension
   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++)
         prod_in[d] = POS_BITS'({{(POS_BITS-DIM_BITS){1'b0}}, lane_in.coord[d]}
                      * {{(POS_BITS-STR_BITS){1'b0}}, stride[d]});
   end

   always_comb begin
      sum_in = '0;
      for (int d = 0; d < NUM_DIMS; d++) sum_in = sum_in + prod_ff[d];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else if (en) begin
         mul_valid_ff <= lane_in.valid;
         valid_ff     <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff      <= prod_in;
         mul_bcast_ff <= lane_in.q;
         mul_err_ff   <= lane_in.err;
         sum_ff       <= sum_in;
         bcast_ff     <= mul_bcast_ff;
         err_ff       <= mul_err_ff;
      end
   end

   assign out_valid  = valid_ff;
   assign out_offset = sum_ff;
   assign out_bcast  = bcast_ff;
   assign out_err    = err_ff;
endmodule

// ===== hdl/tensor_gather_scatter_address_gen_top.sv =====
// ---------------------------------------------------------------------------
// tensor_gather_scatter_address_gen_top: address generator for advanced indexing
// Turns an output position plus index values into a flat source offset.
// ---------------------------------------------------------------------------
// Usage:
//   req_ carries one request per beat: the output position and four index
//   values. rsp_ returns the source offset, the broadcast entry and an error
//   flag for any clamped index. csr_ writes rank, the indexed mask and the
//   four dimension sizes; write only while no request is in flight.
//   A request enters in every cycle unless the row stalls: throughput is one
//   per clock. The path is one entry stage, a row of 256 division cells (four
//   mixed-radix digits of 64 quotient bits, one bit per cell) and two
//   stages of multiply and sum.
//   Reset empties the row and restores rank 1, mask 1 and all sizes 1.
//   When rsp_tready is low with a response waiting, the whole row holds
//   and req_tready drops until the response is taken.
// ---------------------------------------------------------------------------
module tensor_gather_scatter_address_gen_top (
   input  logic                                clock,
   input  logic                                reset,
   // out_position[63:0], index_0[95:64], index_1[127:96],
   // index_2[159:128], index_3[191:160]
   input  logic [tgs_pkg::REQ_BITS-1:0]        req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // source_offset[63:0], bcast_entry[127:64], index_error[128], zero pad
   output logic [tgs_pkg::RSP_BITS-1:0]        rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tgs_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tgs_pkg::DIM_BITS-1:0]        csr_data
);
   import tgs_pkg::*;

   logic [RANK_BITS-1:0]             rank_ff;
   logic [NUM_DIMS-1:0]              mask_ff;
   coord_vec_type                    size_ff;
   coord_vec_type                    eff;
   coord_vec_type                    divisor;
   logic [NUM_DIMS-1:0]              used, pass, indexed;
   logic [NUM_DIMS-1:0][STR_BITS-1:0] stride_in, stride_ff;
   logic [NUM_DIMS-1:0][IDX_BITS-1:0] index;
   logic                             en;
   logic                             out_valid, out_err;
   logic [POS_BITS-1:0]              out_offset, out_bcast;
   lane_type                         lane [NUM_CELLS+1];

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= RANK_BITS'(1);
         mask_ff <= NUM_DIMS'(1);
         for (int d = 0; d < NUM_DIMS; d++) size_ff[d] <= DIM_BITS'(1);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RANK:  rank_ff    <= csr_data[RANK_BITS-1:0];
            CSR_MASK:  mask_ff    <= csr_data[NUM_DIMS-1:0];
            CSR_SIZE0: size_ff[0] <= csr_data;
            CSR_SIZE1: size_ff[1] <= csr_data;
            CSR_SIZE2: size_ff[2] <= csr_data;
            CSR_SIZE3: size_ff[3] <= csr_data;
            default:   ;
         endcase
      end
   end

   // dimension roles from rank and mask
   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         eff[d]     = eff_size(size_ff[d]);
         used[d]    = (d == 0) || (RANK_BITS'(d) < rank_ff);
         indexed[d] = used[d] && mask_ff[d];
         pass[d]    = used[d] && !mask_ff[d];
         divisor[d] = pass[d] ? eff[d] : DIM_BITS'(1);
      end
   end

   // row-major strides, registered as a short chain
   always_comb begin
      stride_in[NUM_DIMS-1] = STR_BITS'(1);
      for (int d = 0; d < NUM_DIMS - 1; d++)
         stride_in[d] = STR_BITS'({{(STR_BITS-DIM_BITS){1'b0}},
                                   (used[d+1] ? eff[d+1] : DIM_BITS'(1))}
                                  * stride_ff[d+1]);
   end

   always_ff @(posedge clock) begin
      stride_ff <= stride_in;
   end

   // stall the whole row while a response waits
   assign en         = !out_valid || rsp_tready;
   assign req_tready = en;

   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++)
         index[d] = req_tdata[POS_BITS + d*IDX_BITS +: IDX_BITS];
   end

   tgs_index u_index (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_valid (req_tvalid),
      .position  (req_tdata[POS_BITS-1:0]),
      .index     (index),
      .size      (eff),
      .indexed   (indexed),
      .lane_out  (lane[0])
   );

   // innermost dimension first, one digit per 64 cells
   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      localparam int Dim = NUM_DIMS - 1 - c / POS_BITS;
      tgs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .lane_in  (lane[c]),
         .divisor  (divisor[Dim]),
         .last     ((c % POS_BITS) == POS_BITS - 1),
         .wr       (pass[Dim]),
         .dim      (DIM_SEL_BITS'(Dim)),
         .lane_out (lane[c+1])
      );
   end

   tgs_offset u_offset (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .lane_in    (lane[NUM_CELLS]),
      .stride     (stride_ff),
      .out_valid  (out_valid),
      .out_offset (out_offset),
      .out_bcast  (out_bcast),
      .out_err    (out_err)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {{(RSP_BITS-2*POS_BITS-1){1'b0}}, out_err, out_bcast, out_offset};
endmodule

// ===== hdl/tgs_checker.sv =====
// ---------------------------------------------------------------------------
// tgs_checker: port-level checks for the address generator
// Watches the request and response channels of the top level.
// ---------------------------------------------------------------------------
module tgs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [tgs_pkg::RSP_BITS-1:0] rsp_tdata
);
   import tgs_pkg::*;

   // reset empties the row
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // no stall without a waiting response
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

   // padding bits stay zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_BITS-1:2*POS_BITS+1] == '0)
      else $error("response padding not zero");
endmodule

bind tensor_gather_scatter_address_gen_top tgs_checker u_tgs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: gather/scatter address generator check
// Drives requests under several configurations and idling phases, predicts
// offset, broadcast entry and clamp flag per request and compares in order.
// ---------------------------------------------------------------------------

// Offset predictor and in-order store of expected responses
class offset_scoreboard;
   logic [2:0]  rank_reg;
   logic [3:0]  mask_reg;
   logic [15:0] size_reg [4];
   logic [128:0] pending [$];
   int unsigned mismatches;
   int unsigned checked;

   function void reset_regs();
      rank_reg = 3'd1;
      mask_reg = 4'd1;
      for (int d = 0; d < 4; d++) size_reg[d] = 16'd1;
      pending.delete();
   endfunction

   function void write_reg(input logic [2:0] idx, input logic [15:0] val);
      case (idx)
         tgs_pkg::CSR_RANK: rank_reg = val[2:0];
         tgs_pkg::CSR_MASK: mask_reg = val[3:0];
         tgs_pkg::CSR_SIZE0: size_reg[0] = val;
         tgs_pkg::CSR_SIZE1: size_reg[1] = val;
         tgs_pkg::CSR_SIZE2: size_reg[2] = val;
         tgs_pkg::CSR_SIZE3: size_reg[3] = val;
         default: ;
      endcase
   endfunction

   function logic [63:0] dim_len(input int d);
      return (size_reg[d] == 16'd0) ? 64'd1 : {48'd0, size_reg[d]};
   endfunction

   // work out offset, broadcast entry and clamp flag for one request
   function void note_request(input logic [191:0] req);
      logic [63:0] stride [4];
      logic [63:0] pass_span, bcast, rem, offset, s;
      logic signed [63:0] v;
      logic err;
      int n;
      n = (rank_reg == 0) ? 1 : (rank_reg > 4) ? 4 : rank_reg;
      stride[n-1] = 64'd1;
      for (int d = n - 2; d >= 0; d--) stride[d] = stride[d+1] * dim_len(d + 1);
      pass_span = 64'd1;
      for (int d = 0; d < n; d++) if (!mask_reg[d]) pass_span *= dim_len(d);
      if (pass_span != 0) begin
         bcast = req[63:0] / pass_span;
         rem = req[63:0] % pass_span;
      end else begin
         bcast = req[63:0];
         rem = 64'd0;
      end
      offset = 64'd0;
      err = 1'b0;
      for (int d = 0; d < n; d++) begin
         if (mask_reg[d]) begin
            s = dim_len(d);
            v = 64'(signed'(req[64+32*d +: 32]));
            if (v < 0) v += signed'(s);
            if (v < 0) begin
               v = 0;
               err = 1'b1;
            end else if (v >= signed'(s)) begin
               v = signed'(s - 1);
               err = 1'b1;
            end
            offset += v * stride[d];
         end
      end
      for (int d = n - 1; d >= 0; d--) begin
         if (!mask_reg[d]) begin
            s = dim_len(d);
            offset += (rem % s) * stride[d];
            rem = rem / s;
         end
      end
      pending.insert(pending.size(), {err, bcast, offset});
   endfunction

   function void check_response(input logic [135:0] rsp);
      logic [128:0] want;
      checked++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response %h", rsp);
         return;
      end
      want = pending.pop_front();
      if (rsp[63:0] !== want[63:0] || rsp[127:64] !== want[127:64]
          || rsp[128] !== want[128]) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: offset %h/%h bcast %h/%h err %b/%b",
                     want[63:0], rsp[63:0], want[127:64], rsp[127:64],
                     want[128], rsp[128]);
      end
   endfunction
endclass

module testbench;
   localparam int LATENCY = 259;
   localparam longint CYCLE_LIMIT = 3000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [191:0] req_tdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [15:0]  csr_data = '0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   longint      cycles = 0;
   int unsigned requests_sent = 0;
   offset_scoreboard board;

   tensor_gather_scatter_address_gen_top dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // check accepted responses and randomise back-pressure
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout");
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      csr_valid <= 1'b0;
   endtask

   task automatic send_request(input logic [191:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= data;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_request(data);
      requests_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic configure(input logic [2:0] rk, input logic [3:0] msk,
                            input logic [15:0] s0, input logic [15:0] s1,
                            input logic [15:0] s2, input logic [15:0] s3);
      drain();
      write_csr(tgs_pkg::CSR_RANK, {13'd0, rk});
      write_csr(tgs_pkg::CSR_MASK, {12'd0, msk});
      write_csr(tgs_pkg::CSR_SIZE0, s0);
      write_csr(tgs_pkg::CSR_SIZE1, s1);
      write_csr(tgs_pkg::CSR_SIZE2, s2);
      write_csr(tgs_pkg::CSR_SIZE3, s3);
   endtask

   // index near the legal range mostly, fully random otherwise
   function automatic logic [31:0] pick_index(input logic [15:0] sz);
      int s;
      s = (sz == 0) ? 1 : sz;
      case ($urandom_range(9))
         0: return $urandom;
         1: return -s - $urandom_range(3);
         2: return s + $urandom_range(3);
         default: return $urandom_range(2 * s - 1) - s;
      endcase
   endfunction

   function automatic logic [191:0] random_request();
      logic [63:0] pos;
      logic [63:0] span;
      span = 1;
      for (int d = 0; d < 4; d++)
         span *= (board.size_reg[d] == 0) ? 1 : board.size_reg[d];
      if ($urandom_range(7) == 0) pos = {$urandom, $urandom};
      else pos = (span == 0) ? {$urandom, $urandom}
                             : {$urandom, $urandom} % (span * 4);
      return {pick_index(board.size_reg[3]), pick_index(board.size_reg[2]),
              pick_index(board.size_reg[1]), pick_index(board.size_reg[0]), pos};
   endfunction

   task automatic random_batch(input int count);
      for (int i = 0; i < count; i++) begin
         send_request(random_request());
         if ($urandom_range(15) == 0) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   initial begin
      logic [15:0] s [4];
      board = new();
      board.reset_regs();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, extremes, wrap, clamp, zero sizes
      send_request({32'h0, 32'h0, 32'h0, 32'h0, 64'd0});
      send_request({32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF,
                    64'hFFFF_FFFF_FFFF_FFFF});
      configure(3'd4, 4'b0101, 16'd7, 16'd5, 16'd3, 16'd9);
      send_request({32'd8, 32'd0, 32'hFFFFFFF9, 32'hFFFFFFF8, 64'd44});
      send_request({32'hFFFFFFFF, 32'd2, 32'd3, 32'd6, 64'd45});
      send_request({32'h80000000, 32'h7FFFFFFF, 32'd0, 32'h7FFFFFFF,
                    64'hFFFF_FFFF_FFFF_FFFF});
      configure(3'd0, 4'b0000, 16'd0, 16'd0, 16'd0, 16'd0);
      send_request({32'd5, 32'd5, 32'd5, 32'd5, 64'd1234567});
      configure(3'd7, 4'b0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request({128'd0, 64'hFFFF_FFFF_FFFF_FFFF});
      send_request({128'd0, 64'h0001_0002_0003_0004});
      configure(3'd4, 4'b1111, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request({32'hFFFF0001, 32'hFFFF, 32'hFFFFFFFF, 32'd65534, 64'd99});
      configure(3'd2, 4'b1110, 16'd10, 16'd4, 16'd1, 16'd1);
      send_request({32'd3, 32'd3, 32'd9, 32'd9, 64'd57});

      // random phases: varying settings and idling
      for (int phase = 0; phase < 16; phase++) begin
         for (int d = 0; d < 4; d++)
            case ($urandom_range(5))
               0: s[d] = 16'hFFFF;
               1: s[d] = 16'($urandom);
               2: s[d] = 16'd0;
               default: s[d] = 16'($urandom_range(1, 12));
            endcase
         configure(3'($urandom_range(7)), 4'($urandom_range(15)),
                   s[0], s[1], s[2], s[3]);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         random_batch(42);
         // hold off until every response is back, then go on
         req_tvalid <= 1'b0;
         while (board.pending.size() != 0) @(posedge clock);
         random_batch(42);
      end

      drain();
      $display("Covered %0d requests, %0d responses over 16 random settings,",
               requests_sent, board.checked);
      $display("ranks 0..7, all masks, zero and full-width sizes, four idle mixes.");
      if (board.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
